/* hw/rtl/i2cm_pkg.sv */
`default_nettype none

package i2cm_pkg;

  // configuration and field widths
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned STEP_W       = 6;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned TIMER_BITS_D = 16;
  localparam logic [CFG_W-1:0] DELAY_RESET = 16'd120;

  // command codes carried on the action field
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_ACK   = 3'd5,
    CMD_NACK  = 3'd6,
    CMD_CHECK = 3'd7
  } cmd_t;

  // line drive pair
  typedef struct packed {
    logic scl;
    logic sda;
  } lines_t;

  // number of line phases per command
  function automatic logic [STEP_W-1:0] phase_count(input cmd_t cmd);
    logic [STEP_W-1:0] n;
    unique case (cmd)
      CMD_IDLE:  n = 6'd0;
      CMD_START: n = 6'd3;
      CMD_STOP:  n = 6'd2;
      CMD_WRITE: n = 6'd32;
      CMD_READ:  n = 6'd16;
      default:   n = 6'd3;
    endcase
    return n;
  endfunction

  // line levels set when a phase begins
  function automatic lines_t enter_phase(input cmd_t cmd, input logic [STEP_W-1:0] step,
                                         input logic msb, input lines_t cur);
    lines_t l;
    l = cur;
    unique case (cmd)
      CMD_START: begin
        if (step == '0) begin
          l.scl = 1'b1;
          l.sda = 1'b1;
        end else if (step == 6'd1) begin
          l.sda = 1'b0;
        end else begin
          l.scl = 1'b0;
        end
      end
      CMD_STOP: begin
        if (step == '0) begin
          l.scl = 1'b1;
          l.sda = 1'b0;
        end else begin
          l.sda = 1'b1;
        end
      end
      CMD_WRITE: begin
        case (step[1:0])
          2'd0: l.sda = msb;
          2'd1: l.scl = 1'b1;
          2'd2: l.scl = 1'b0;
          default: begin
            // release sda after the last data bit
            if (step[STEP_W-1:2] == 4'd7) l.sda = 1'b1;
          end
        endcase
      end
      CMD_READ: begin
        if (!step[0]) begin
          if (step == '0) l.sda = 1'b1;
          l.scl = 1'b1;
        end else begin
          l.scl = 1'b0;
        end
      end
      CMD_ACK, CMD_NACK, CMD_CHECK: begin
        if (step == '0) l.sda = (cmd != CMD_ACK);
        else if (step == 6'd1) l.scl = 1'b1;
        else l.scl = 1'b0;
      end
      default: l = cur;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/i2c_master_bit_sequencer.sv */
// channel  | direction | handshake            | payload
// cfg      | in        | cfg_valid/cfg_ready  | cfg_data (delay ticks per phase)
// in       | in        | in_valid/in_ready    | in_action, in_write_data, in_sda_in
// out      | out       | out_valid/out_ready  | scl, sda, busy, done, read byte, ack, rejected
//
// one transaction in, one out; a transaction is taken every cycle while in_ready is high
// the sequencer state and the result register update on the same edge
// in_ready is high while the result register is empty or being drained
// synchronous active-low reset: lines released, idle, delay 120
// cfg_ready is always high; write only while idle
`default_nettype none

module i2c_master_bit_sequencer
  import i2cm_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TIMER_BITS_D
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_action,
  input  wire logic [BYTE_W-1:0] in_write_data,
  input  wire logic              in_sda_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_scl_out,
  output logic                   out_sda_out,
  output logic                   out_busy_res,
  output logic                   out_done_res,
  output logic [BYTE_W-1:0]      out_read_byte_value,
  output logic                   out_ack_missing,
  output logic                   out_rejected
);

  logic [CFG_W-1:0]      delay_r;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt, timer_load;
  logic [STEP_W-1:0]     step_r, step_nxt, step_inc;
  cmd_t                  cmd_r, cmd_nxt, act;
  logic [BYTE_W-1:0]     shift_r, shift_nxt, rdval_r, rdval_nxt;
  logic                  ack_r, ack_nxt;
  lines_t                lines_r, lines_nxt;
  logic                  rej, done, in_fire, phase_end;
  logic [CFG_W-1:0]      delay_min;

  logic                  out_valid_r;
  logic                  out_done_r, out_rej_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign act       = cmd_t'(in_action);

  // phase length: zero counts as one, saturate to the timer width
  assign delay_min = (delay_r == '0) ? CFG_W'(1) : delay_r;
  generate
    if (TIMER_BITS >= CFG_W) begin : g_load_wide
      assign timer_load = (TIMER_BITS)'(delay_min);
    end else begin : g_load_sat
      assign timer_load = (delay_min[CFG_W-1:TIMER_BITS] != '0) ? '1
                                                               : delay_min[TIMER_BITS-1:0];
    end
  endgenerate

  assign phase_end = (timer_r <= (TIMER_BITS)'(1));
  assign step_inc  = step_r + STEP_W'(1);

  // sequencer next state
  always_comb begin
    timer_nxt = timer_r;
    step_nxt  = step_r;
    cmd_nxt   = cmd_r;
    shift_nxt = shift_r;
    rdval_nxt = rdval_r;
    ack_nxt   = ack_r;
    lines_nxt = lines_r;
    rej       = 1'b0;
    done      = 1'b0;
    if (in_fire) begin
      if (cmd_r == CMD_IDLE) begin
        if (act != CMD_IDLE) begin
          cmd_nxt   = act;
          step_nxt  = '0;
          shift_nxt = (act == CMD_WRITE) ? in_write_data : '0;
          lines_nxt = enter_phase(act, '0, shift_nxt[BYTE_W-1], lines_r);
          timer_nxt = timer_load;
        end
      end else begin
        rej = (act != CMD_IDLE);
        if (timer_r != '0) timer_nxt = timer_r - (TIMER_BITS)'(1);
        if (phase_end) begin
          // end-of-phase sampling and shifting
          if (cmd_r == CMD_READ && !step_r[0]) begin
            shift_nxt = {shift_r[BYTE_W-2:0], in_sda_in};
          end else if (cmd_r == CMD_WRITE && step_r[1:0] == 2'd3) begin
            shift_nxt = {shift_r[BYTE_W-2:0], 1'b0};
          end else if (cmd_r == CMD_CHECK && step_r == STEP_W'(1)) begin
            ack_nxt = in_sda_in;
          end
          if (step_inc >= phase_count(cmd_r)) begin
            if (cmd_r == CMD_READ) rdval_nxt = shift_nxt;
            if (cmd_r == CMD_ACK) lines_nxt.sda = 1'b1;
            cmd_nxt  = CMD_IDLE;
            step_nxt = '0;
            done     = 1'b1;
          end else begin
            step_nxt  = step_inc;
            lines_nxt = enter_phase(cmd_r, step_inc, shift_nxt[BYTE_W-1], lines_r);
            timer_nxt = timer_load;
          end
        end
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delay_r <= cfg_data;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r     <= '0;
      step_r      <= '0;
      cmd_r       <= CMD_IDLE;
      shift_r     <= '0;
      rdval_r     <= '0;
      ack_r       <= 1'b0;
      lines_r.scl <= 1'b1;
      lines_r.sda <= 1'b1;
    end else begin
      timer_r <= timer_nxt;
      step_r  <= step_nxt;
      cmd_r   <= cmd_nxt;
      shift_r <= shift_nxt;
      rdval_r <= rdval_nxt;
      ack_r   <= ack_nxt;
      lines_r <= lines_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_done_r <= done;
      out_rej_r  <= rej;
    end
  end

  // level outputs mirror the state, which changes only with a transaction
  assign out_valid           = out_valid_r;
  assign out_scl_out         = lines_r.scl;
  assign out_sda_out         = lines_r.sda;
  assign out_busy_res        = (cmd_r != CMD_IDLE);
  assign out_done_res        = out_done_r;
  assign out_read_byte_value = rdval_r;
  assign out_ack_missing     = ack_r;
  assign out_rejected        = out_rej_r;

  // idle sequencer sits at step zero
  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r == CMD_IDLE) |-> (step_r == '0))
    else $error("idle with nonzero step");

  // an active command always has a running phase timer
  a_busy_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r != CMD_IDLE) |-> (timer_r != '0))
    else $error("busy with expired timer");

  // step stays inside the command's phase list
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r != CMD_IDLE) |-> (step_r < phase_count(cmd_r)))
    else $error("step beyond phase count");

  // a command taken while idle starts a sequence
  a_start_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cmd_r == CMD_IDLE && act != CMD_IDLE) |=> (cmd_r != CMD_IDLE))
    else $error("command not started");

  // a finishing result never reports busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> !out_busy_res)
    else $error("done while busy");

endmodule

`default_nettype wire

/* test/i2c_line_checker.sv */
`timescale 1ns / 100ps

module i2c_line_checker
  import i2cm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [2:0]        in_action,
  input  wire logic [BYTE_W-1:0] in_write_data,
  input  wire logic              in_sda_in,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic              out_scl_out,
  input  wire logic              out_sda_out,
  input  wire logic              out_busy_res,
  input  wire logic              out_done_res,
  input  wire logic [BYTE_W-1:0] out_read_byte_value,
  input  wire logic              out_ack_missing,
  input  wire logic              out_rejected,
  output int                     fail_count,
  output int                     pending,
  output logic                   seq_busy
);

  // one result transaction as seen on the output channel
  typedef struct packed {
    logic              scl;
    logic              sda;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rd_byte;
    logic              ack_missing;
    logic              rejected;
  } line_result_t;

  line_result_t expected_q[$];

  // sequencer state mirror
  logic [CFG_W-1:0]        delay_cfg = DELAY_RESET;
  logic [TIMER_BITS_D-1:0] timer     = '0;
  logic [STEP_W-1:0]       step      = '0;
  cmd_t                    cur_cmd   = CMD_IDLE;
  logic [BYTE_W-1:0]       shifter   = '0;
  logic [BYTE_W-1:0]       rd_byte   = '0;
  logic                    ack_miss  = 1'b0;
  logic                    scl_lvl   = 1'b1;
  logic                    sda_lvl   = 1'b1;

  int mismatches = 0;
  int queued     = 0;

  assign fail_count = mismatches;
  assign pending    = queued;
  assign seq_busy   = (cur_cmd != CMD_IDLE);

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // zero delay behaves as one tick per phase
  function automatic logic [TIMER_BITS_D-1:0] phase_len();
    return (delay_cfg == '0) ? TIMER_BITS_D'(1) : TIMER_BITS_D'(delay_cfg);
  endfunction

  // line levels applied when a phase begins
  task automatic drive_phase();
    case (cur_cmd)
      CMD_START: begin
        if (step == 0) begin
          scl_lvl = 1'b1;
          sda_lvl = 1'b1;
        end else if (step == 1) begin
          sda_lvl = 1'b0;
        end else begin
          scl_lvl = 1'b0;
        end
      end
      CMD_STOP: begin
        if (step == 0) begin
          scl_lvl = 1'b1;
          sda_lvl = 1'b0;
        end else begin
          sda_lvl = 1'b1;
        end
      end
      CMD_WRITE: begin
        case (step[1:0])
          2'd0: sda_lvl = shifter[7];
          2'd1: scl_lvl = 1'b1;
          2'd2: scl_lvl = 1'b0;
          default: begin
            // let go of sda once the last bit is clocked out
            if (step[STEP_W-1:2] == 7) sda_lvl = 1'b1;
          end
        endcase
      end
      CMD_READ: begin
        if (!step[0]) begin
          if (step == 0) sda_lvl = 1'b1;
          scl_lvl = 1'b1;
        end else begin
          scl_lvl = 1'b0;
        end
      end
      CMD_ACK, CMD_NACK, CMD_CHECK: begin
        if (step == 0) sda_lvl = (cur_cmd != CMD_ACK);
        else if (step == 1) scl_lvl = 1'b1;
        else scl_lvl = 1'b0;
      end
      default: ;
    endcase
  endtask

  // advance the mirror by one input transaction and form its result
  task automatic predict_item(input cmd_t act, input logic [BYTE_W-1:0] wd, input logic sda,
                              output line_result_t r);
    logic              rej;
    logic              fin;
    logic [STEP_W-1:0] n_phases;
    rej = 1'b0;
    fin = 1'b0;
    if (cur_cmd == CMD_IDLE) begin
      if (act != CMD_IDLE) begin
        cur_cmd = act;
        step    = '0;
        shifter = (act == CMD_WRITE) ? wd : '0;
        drive_phase();
        timer = phase_len();
      end
    end else begin
      if (act != CMD_IDLE) rej = 1'b1;
      if (timer != 0) timer = timer - 1'b1;
      if (timer == 0) begin
        // sampling and shifting at the end of a phase
        if (cur_cmd == CMD_READ && !step[0]) shifter = {shifter[BYTE_W-2:0], sda};
        else if (cur_cmd == CMD_WRITE && step[1:0] == 2'd3) shifter = shifter << 1;
        else if (cur_cmd == CMD_CHECK && step == 1) ack_miss = sda;
        step = step + 1'b1;
        case (cur_cmd)
          CMD_START: n_phases = STEP_W'(3);
          CMD_STOP:  n_phases = STEP_W'(2);
          CMD_WRITE: n_phases = STEP_W'(32);
          CMD_READ:  n_phases = STEP_W'(16);
          default:   n_phases = STEP_W'(3);
        endcase
        if (step >= n_phases) begin
          if (cur_cmd == CMD_READ) rd_byte = shifter;
          if (cur_cmd == CMD_ACK) sda_lvl = 1'b1;
          cur_cmd = CMD_IDLE;
          step    = '0;
          fin     = 1'b1;
        end else begin
          drive_phase();
          timer = phase_len();
        end
      end
    end
    r = '{scl_lvl, sda_lvl, cur_cmd != CMD_IDLE, fin, rd_byte, ack_miss, rej};
  endtask

  // watch all three channels, compare before predicting
  always @(posedge clk) begin : watch
    line_result_t got;
    line_result_t want;
    if (!rst_n) begin
      delay_cfg = DELAY_RESET;
      timer     = '0;
      step      = '0;
      cur_cmd   = CMD_IDLE;
      shifter   = '0;
      rd_byte   = '0;
      ack_miss  = 1'b0;
      scl_lvl   = 1'b1;
      sda_lvl   = 1'b1;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_scl_out, out_sda_out, out_busy_res, out_done_res, out_read_byte_value,
                out_ack_missing, out_rejected};
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing pending", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.scl !== want.scl) report_mismatch("scl_out", got.scl, want.scl);
          if (got.sda !== want.sda) report_mismatch("sda_out", got.sda, want.sda);
          if (got.busy !== want.busy) report_mismatch("busy_res", got.busy, want.busy);
          if (got.done !== want.done) report_mismatch("done_res", got.done, want.done);
          if (got.rd_byte !== want.rd_byte)
            report_mismatch("read_byte_value", got.rd_byte, want.rd_byte);
          if (got.ack_missing !== want.ack_missing)
            report_mismatch("ack_missing", got.ack_missing, want.ack_missing);
          if (got.rejected !== want.rejected)
            report_mismatch("rejected", got.rejected, want.rejected);
        end
      end
      if (in_valid && in_ready) begin
        predict_item(cmd_t'(in_action), in_write_data, in_sda_in, want);
        expected_q.push_back(want);
      end
      // a new delay applies from the next transaction on
      if (cfg_valid && cfg_ready) delay_cfg = cfg_data;
    end
    queued = expected_q.size();
  end

endmodule

/* test/i2c_master_bit_sequencer_test.sv */
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_test;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        in_action;
  logic [BYTE_W-1:0] in_write_data;
  logic              in_sda_in;
  logic              out_valid;
  logic              out_ready;
  logic              out_scl_out;
  logic              out_sda_out;
  logic              out_busy_res;
  logic              out_done_res;
  logic [BYTE_W-1:0] out_read_byte_value;
  logic              out_ack_missing;
  logic              out_rejected;

  int   fail_count;
  int   pending;
  logic seq_busy;

  int in_gap_pct  = 8;
  int out_gap_pct = 71;
  int cycle_count = 0;

  i2c_master_bit_sequencer i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_write_data       (in_write_data),
    .in_sda_in           (in_sda_in),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_scl_out         (out_scl_out),
    .out_sda_out         (out_sda_out),
    .out_busy_res        (out_busy_res),
    .out_done_res        (out_done_res),
    .out_read_byte_value (out_read_byte_value),
    .out_ack_missing     (out_ack_missing),
    .out_rejected        (out_rejected)
  );

  i2c_line_checker u_line_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_write_data       (in_write_data),
    .in_sda_in           (in_sda_in),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_scl_out         (out_scl_out),
    .out_sda_out         (out_sda_out),
    .out_busy_res        (out_busy_res),
    .out_done_res        (out_done_res),
    .out_read_byte_value (out_read_byte_value),
    .out_ack_missing     (out_ack_missing),
    .out_rejected        (out_rejected),
    .fail_count          (fail_count),
    .pending             (pending),
    .seq_busy            (seq_busy)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_gap_pct);
  end

  function automatic logic pick_sda(input int mode);
    return (mode == 2) ? logic'($urandom_range(1)) : logic'(mode[0]);
  endfunction

  // one input transaction, entered and left at a falling edge
  task automatic push_item(input logic [2:0] act, input logic [BYTE_W-1:0] wd,
                           input logic sda);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_write_data <= wd;
    in_sda_in     <= sda;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // issue a command and tick until the sequencer is idle again
  task automatic run_command(input logic [2:0] act, input logic [BYTE_W-1:0] wd,
                             input int sda_mode);
    push_item(act, wd, pick_sda(sda_mode));
    while (seq_busy) push_item(CMD_IDLE, BYTE_W'($urandom), pick_sda(sda_mode));
  endtask

  // finish the running command, drain results, then change the phase delay
  task automatic write_delay(input logic [CFG_W-1:0] value);
    while (seq_busy) push_item(CMD_IDLE, BYTE_W'($urandom), logic'($urandom_range(1)));
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly complete commands with ticks, some commands thrown in while busy
  task automatic random_traffic(input int n);
    logic [2:0] act;
    for (int i = 0; i < n; i++) begin
      if (!seq_busy)
        act = ($urandom_range(99) < 85) ? 3'($urandom_range(7, 1)) : 3'(CMD_IDLE);
      else
        act = ($urandom_range(99) < 6) ? 3'($urandom_range(7, 1)) : 3'(CMD_IDLE);
      push_item(act, BYTE_W'($urandom), logic'($urandom_range(1)));
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_action     = CMD_IDLE;
    in_write_data = '0;
    in_sda_in     = 1'b0;
    out_ready     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sender mostly busy, receiver mostly stalled
    in_gap_pct  = 8;
    out_gap_pct = 71;
    run_command(CMD_CHECK, 8'h5A, 2);

    // directed commands, zero delay acts as one
    write_delay('0);
    push_item(CMD_IDLE, 8'hFF, 1'b0);
    run_command(CMD_START, 8'h00, 2);
    run_command(CMD_WRITE, 8'hFF, 2);
    run_command(CMD_WRITE, 8'h00, 2);
    run_command(CMD_CHECK, 8'h00, 0);
    run_command(CMD_CHECK, 8'h00, 1);
    run_command(CMD_READ, 8'h00, 1);
    run_command(CMD_READ, 8'hFF, 0);
    run_command(CMD_ACK, 8'h00, 2);
    run_command(CMD_NACK, 8'h00, 2);
    // a write is taken while idle, then a read arriving while busy is turned away
    push_item(CMD_WRITE, 8'hA5, 1'b0);
    push_item(CMD_READ, 8'h3C, 1'b1);
    run_command(CMD_IDLE, 8'h00, 2);
    run_command(CMD_STOP, 8'h00, 2);

    write_delay(16'd1);
    random_traffic(160);

    // sender mostly idle, receiver mostly ready
    in_gap_pct  = 71;
    out_gap_pct = 8;
    write_delay(16'd2);
    random_traffic(120);
    write_delay(16'd3);
    random_traffic(100);

    // full rate both sides
    in_gap_pct  = 0;
    out_gap_pct = 0;
    write_delay(16'd5);
    random_traffic(140);

    // longest phase, only the opening of a command
    write_delay(16'hFFFF);
    push_item(CMD_STOP, 8'h00, 1'b0);
    random_traffic(40);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/i2cm_pkg.sv
hw/rtl/i2c_master_bit_sequencer.sv
test/i2c_line_checker.sv
test/i2c_master_bit_sequencer_test.sv
